@@ hw/rtl/dcs_pkg.sv @@
`default_nettype none
package dcs_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_CNT_W   = 16;
    localparam int CENTER_W    = 11;
    localparam int STEP_W      = 8;
    localparam int LIMIT_W     = 9;
    localparam int SPEED_W     = 10;
    localparam int RAMP_W      = 9;
    localparam int AIM_W       = 11;
    localparam int PULSE_W     = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_VERT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AIM_LIMIT    = 3'd6;

    localparam logic [CENTER_W-1:0] CENTER_RESET    = 11'd1500;
    localparam logic [STEP_W-1:0]   SLEW_STEP_RESET = 8'd50;
    localparam logic [STEP_W-1:0]   RAMP_STEP_RESET = 8'd30;
    localparam logic [LIMIT_W-1:0]  AIM_LIMIT_RESET = 9'd500;

    localparam logic signed [SPEED_W-1:0] SPEED_TURN_INNER = 10'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_REVERSE    = -10'sd200;

    typedef enum logic [1:0] {
        REQ_CMD,
        REQ_SLEW,
        REQ_AIM,
        REQ_ENC
    } req_t;

    typedef enum logic [1:0] {
        DIR_STOP,
        DIR_REV,
        DIR_FWD,
        DIR_KEEP
    } dir_t;

    typedef enum logic [1:0] {
        RAMP_ZERO,
        RAMP_UP,
        RAMP_DOWN
    } ramp_code_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FIRE,
        OP_MOVE,
        OP_RAMP_BASE,
        OP_RAMP_VERT,
        OP_SLEW,
        OP_AIM,
        OP_ENC
    } op_kind_t;

    typedef struct packed {
        op_kind_t                    kind;
        logic                        perr;
        logic signed [SPEED_W-1:0]   tgt_left;
        logic signed [SPEED_W-1:0]   tgt_right;
        logic                        clr_cnt;
        ramp_code_t                  ramp;
        logic                        enc_left;
        logic                        enc_right;
    } op_t;

    typedef struct packed {
        logic [CENTER_W-1:0] neutral_left;
        logic [CENTER_W-1:0] neutral_right;
        logic [CENTER_W-1:0] neutral_base;
        logic [CENTER_W-1:0] neutral_vert;
        logic [STEP_W-1:0]   slew_step;
        logic [STEP_W-1:0]   ramp_step;
        logic [LIMIT_W-1:0]  aim_limit;
    } cfg_t;

    function automatic logic signed [SPEED_W-1:0] turn_speed(input logic [2:0] lvl_m1);
        logic signed [SPEED_W-1:0] s;
        case (lvl_m1)
            3'd0:    s = 10'sd6;
            3'd1:    s = 10'sd24;
            3'd2:    s = 10'sd54;
            3'd3:    s = 10'sd96;
            3'd4:    s = 10'sd150;
            3'd5:    s = 10'sd216;
            3'd6:    s = 10'sd294;
            default: s = 10'sd384;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dcs_front.sv @@
`default_nettype none
module dcs_front
    import dcs_pkg::*;
(
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] cmd_byte,
    input  wire logic       enc_left,
    input  wire logic       enc_right,
    input  wire logic       q_full,
    output logic            q_push,
    output op_t             q_op
);

    dir_t                      dirs;
    logic [2:0]                lvl_m1;
    logic signed [SPEED_W-1:0] sq;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign dirs     = dir_t'(cmd_byte[7:6]);
    assign lvl_m1   = cmd_byte[3] ? 3'(3'd7 - cmd_byte[3:1]) : cmd_byte[3:1];
    assign sq       = turn_speed(lvl_m1);

    always_comb
    begin
        q_op           = '0;
        q_op.kind      = OP_NOP;
        q_op.ramp      = RAMP_ZERO;
        q_op.enc_left  = enc_left;
        q_op.enc_right = enc_right;
        unique case (req_t'(req_type))
            REQ_CMD:
            begin
                if (^cmd_byte)
                begin
                    q_op.perr = 1'b1;
                end
                else if (cmd_byte[5])
                begin
                    q_op.kind = OP_FIRE;
                end
                else if (cmd_byte[4])
                begin
                    unique case (dirs)
                        DIR_FWD:
                        begin
                            q_op.kind      = OP_MOVE;
                            q_op.tgt_left  = cmd_byte[3] ? SPEED_TURN_INNER : sq;
                            q_op.tgt_right = cmd_byte[3] ? sq : SPEED_TURN_INNER;
                            q_op.clr_cnt   = 1'b1;
                        end
                        DIR_REV:
                        begin
                            q_op.kind      = OP_MOVE;
                            q_op.tgt_left  = SPEED_REVERSE;
                            q_op.tgt_right = SPEED_REVERSE;
                            q_op.clr_cnt   = 1'b1;
                        end
                        DIR_STOP:
                        begin
                            q_op.kind = OP_MOVE;
                        end
                        DIR_KEEP:
                        begin
                            q_op.kind = OP_NOP;
                        end
                    endcase
                end
                else
                begin
                    q_op.kind = cmd_byte[3] ? OP_RAMP_BASE : OP_RAMP_VERT;
                    unique case (dirs)
                        DIR_FWD:  q_op.ramp = cmd_byte[3] ? RAMP_UP : RAMP_DOWN;
                        DIR_REV:  q_op.ramp = cmd_byte[3] ? RAMP_DOWN : RAMP_UP;
                        DIR_STOP: q_op.ramp = RAMP_ZERO;
                        DIR_KEEP: q_op.kind = OP_NOP;
                    endcase
                end
            end
            REQ_SLEW: q_op.kind = OP_SLEW;
            REQ_AIM:  q_op.kind = OP_AIM;
            REQ_ENC:  q_op.kind = OP_ENC;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/dcs_queue.sv @@
`default_nettype none
module dcs_queue
    import dcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output op_t       head_op
);

    op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_op   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            cnt_next = QCNT_W'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = QCNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/dcs_back.sv @@
`default_nettype none
module dcs_back
    import dcs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          q_not_empty,
    input  wire op_t           q_op,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [PULSE_W-1:0] left_pulse,
    output logic [PULSE_W-1:0] right_pulse,
    output logic [PULSE_W-1:0] base_pulse,
    output logic [PULSE_W-1:0] vert_pulse,
    output logic               parity_error,
    output logic               laser_fire,
    output logic [OUT_CNT_W-1:0] count_left,
    output logic [OUT_CNT_W-1:0] count_right
);

    function automatic logic signed [SPEED_W-1:0] slew_toward(
        input logic signed [SPEED_W-1:0] cur,
        input logic signed [SPEED_W-1:0] goal,
        input logic [STEP_W-1:0]         step
    );
        logic signed [SPEED_W:0] d;
        logic signed [SPEED_W:0] mag;
        logic signed [SPEED_W:0] st;
        logic signed [SPEED_W:0] res;
        d   = (SPEED_W+1)'(cur) - (SPEED_W+1)'(goal);
        mag = (d < 0) ? -d : d;
        st  = $signed((SPEED_W+1)'(step));
        if (mag < st)
        begin
            res = (SPEED_W+1)'(goal);
        end
        else if (cur > goal)
        begin
            res = (SPEED_W+1)'(cur) - st;
        end
        else
        begin
            res = (SPEED_W+1)'(cur) + st;
        end
        return res[SPEED_W-1:0];
    endfunction

    function automatic logic signed [AIM_W-1:0] integrate(
        input logic signed [AIM_W-1:0]  aim,
        input logic signed [RAMP_W-1:0] ramp,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [AIM_W:0] s;
        logic signed [AIM_W:0] l;
        logic signed [AIM_W:0] res;
        s = (AIM_W+1)'(aim) + (AIM_W+1)'(ramp);
        l = $signed((AIM_W+1)'(lim));
        if (ramp < 0)
        begin
            res = (s < -l) ? -l : s;
        end
        else
        begin
            res = (s > l) ? l : s;
        end
        return res[AIM_W-1:0];
    endfunction

    function automatic logic [PULSE_W-1:0] pulse_sat(
        input logic [CENTER_W-1:0]      center,
        input logic signed [AIM_W:0]    off
    );
        logic signed [AIM_W+1:0] v;
        logic [PULSE_W-1:0]      res;
        v = $signed((AIM_W+2)'(center)) + (AIM_W+2)'(off);
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > $signed((AIM_W+2)'({PULSE_W{1'b1}})))
        begin
            res = '1;
        end
        else
        begin
            res = v[PULSE_W-1:0];
        end
        return res;
    endfunction

    logic signed [SPEED_W-1:0] tgt_left_reg,   tgt_left_next;
    logic signed [SPEED_W-1:0] tgt_right_reg,  tgt_right_next;
    logic signed [SPEED_W-1:0] spd_left_reg,   spd_left_next;
    logic signed [SPEED_W-1:0] spd_right_reg,  spd_right_next;
    logic signed [RAMP_W-1:0]  ramp_base_reg,  ramp_base_next;
    logic signed [RAMP_W-1:0]  ramp_vert_reg,  ramp_vert_next;
    logic signed [AIM_W-1:0]   aim_base_reg,   aim_base_next;
    logic signed [AIM_W-1:0]   aim_vert_reg,   aim_vert_next;
    logic                      prev_left_reg,  prev_left_next;
    logic                      prev_right_reg, prev_right_next;
    logic [COUNT_WIDTH-1:0]    edges_left_reg, edges_left_next;
    logic [COUNT_WIDTH-1:0]    edges_right_reg, edges_right_next;
    logic                      out_valid_reg,  out_valid_next;
    logic signed [RAMP_W-1:0]  ramp_val;
    logic signed [RAMP_W-1:0]  ramp_pos;
    logic [PULSE_W-1:0]        left_pulse_reg, right_pulse_reg;
    logic [PULSE_W-1:0]        base_pulse_reg, vert_pulse_reg;
    logic                      perr_reg, fire_reg;

    assign q_pop    = q_not_empty && (!out_valid_reg || !out_stall);
    assign ramp_pos = $signed(RAMP_W'(cfg.ramp_step));

    always_comb
    begin
        case (q_op.ramp)
            RAMP_UP:   ramp_val = ramp_pos;
            RAMP_DOWN: ramp_val = -ramp_pos;
            default:   ramp_val = '0;
        endcase
    end

    always_comb
    begin
        tgt_left_next    = tgt_left_reg;
        tgt_right_next   = tgt_right_reg;
        spd_left_next    = spd_left_reg;
        spd_right_next   = spd_right_reg;
        ramp_base_next   = ramp_base_reg;
        ramp_vert_next   = ramp_vert_reg;
        aim_base_next    = aim_base_reg;
        aim_vert_next    = aim_vert_reg;
        prev_left_next   = prev_left_reg;
        prev_right_next  = prev_right_reg;
        edges_left_next  = edges_left_reg;
        edges_right_next = edges_right_reg;
        case (q_op.kind)
            OP_MOVE:
            begin
                tgt_left_next  = q_op.tgt_left;
                tgt_right_next = q_op.tgt_right;
                if (q_op.clr_cnt)
                begin
                    edges_left_next  = '0;
                    edges_right_next = '0;
                end
            end
            OP_RAMP_BASE: ramp_base_next = ramp_val;
            OP_RAMP_VERT: ramp_vert_next = ramp_val;
            OP_SLEW:
            begin
                spd_left_next  = slew_toward(spd_left_reg, tgt_left_reg, cfg.slew_step);
                spd_right_next = slew_toward(spd_right_reg, tgt_right_reg, cfg.slew_step);
            end
            OP_AIM:
            begin
                aim_base_next = integrate(aim_base_reg, ramp_base_reg, cfg.aim_limit);
                aim_vert_next = integrate(aim_vert_reg, ramp_vert_reg, cfg.aim_limit);
            end
            OP_ENC:
            begin
                if (!prev_left_reg && q_op.enc_left)
                begin
                    edges_left_next = COUNT_WIDTH'(edges_left_reg + 1'b1);
                end
                if (!prev_right_reg && q_op.enc_right)
                begin
                    edges_right_next = COUNT_WIDTH'(edges_right_reg + 1'b1);
                end
                prev_left_next  = q_op.enc_left;
                prev_right_next = q_op.enc_right;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_left_reg    <= '0;
            tgt_right_reg   <= '0;
            spd_left_reg    <= '0;
            spd_right_reg   <= '0;
            ramp_base_reg   <= '0;
            ramp_vert_reg   <= '0;
            aim_base_reg    <= '0;
            aim_vert_reg    <= '0;
            prev_left_reg   <= 1'b0;
            prev_right_reg  <= 1'b0;
            edges_left_reg  <= '0;
            edges_right_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                tgt_left_reg    <= tgt_left_next;
                tgt_right_reg   <= tgt_right_next;
                spd_left_reg    <= spd_left_next;
                spd_right_reg   <= spd_right_next;
                ramp_base_reg   <= ramp_base_next;
                ramp_vert_reg   <= ramp_vert_next;
                aim_base_reg    <= aim_base_next;
                aim_vert_reg    <= aim_vert_next;
                prev_left_reg   <= prev_left_next;
                prev_right_reg  <= prev_right_next;
                edges_left_reg  <= edges_left_next;
                edges_right_reg <= edges_right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            left_pulse_reg  <= pulse_sat(cfg.neutral_left, (AIM_W+1)'(spd_left_next));
            right_pulse_reg <= pulse_sat(cfg.neutral_right, -((AIM_W+1)'(spd_right_next)));
            base_pulse_reg  <= pulse_sat(cfg.neutral_base, (AIM_W+1)'(aim_base_next));
            vert_pulse_reg  <= pulse_sat(cfg.neutral_vert, (AIM_W+1)'(aim_vert_next));
            perr_reg        <= q_op.perr;
            fire_reg        <= (q_op.kind == OP_FIRE);
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_pulse   = left_pulse_reg;
    assign right_pulse  = right_pulse_reg;
    assign base_pulse   = base_pulse_reg;
    assign vert_pulse   = vert_pulse_reg;
    assign parity_error = perr_reg;
    assign laser_fire   = fire_reg;
    assign count_left   = OUT_CNT_W'(edges_left_reg);
    assign count_right  = OUT_CNT_W'(edges_right_reg);

endmodule
`default_nettype wire

@@ hw/rtl/drive_command_slew_controller.sv @@
// Path: a word accepted from the input is written into the decode queue, then popped into the
//   output register once that register is free (out_valid low or out_stall low).
// Throughput: one word per cycle while out_stall is low; the two-entry decode queue lets input and output stall apart.
// Reset (rst_n, asynchronous, active low): speeds, targets, ramps, aim, encoder state and counts
//   clear to zero, centers return to 1500, slew step 50, ramp step 30, aim limit 500.
`default_nettype none
module drive_command_slew_controller
    import dcs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            req_type,
    input  wire logic [7:0]            cmd_byte,
    input  wire logic                  enc_left,
    input  wire logic                  enc_right,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PULSE_W-1:0]         left_pulse,
    output logic [PULSE_W-1:0]         right_pulse,
    output logic [PULSE_W-1:0]         base_pulse,
    output logic [PULSE_W-1:0]         vert_pulse,
    output logic                       parity_error,
    output logic                       laser_fire,
    output logic [OUT_CNT_W-1:0]       count_left,
    output logic [OUT_CNT_W-1:0]       count_right,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    op_t  push_op;
    op_t  head_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neutral_left  <= CENTER_RESET;
            cfg_reg.neutral_right <= CENTER_RESET;
            cfg_reg.neutral_base  <= CENTER_RESET;
            cfg_reg.neutral_vert  <= CENTER_RESET;
            cfg_reg.slew_step     <= SLEW_STEP_RESET;
            cfg_reg.ramp_step     <= RAMP_STEP_RESET;
            cfg_reg.aim_limit     <= AIM_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_LEFT:  cfg_reg.neutral_left  <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_RIGHT: cfg_reg.neutral_right <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_BASE:  cfg_reg.neutral_base  <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_VERT:  cfg_reg.neutral_vert  <= cfg_data[CENTER_W-1:0];
                CFG_SLEW_STEP:    cfg_reg.slew_step     <= cfg_data[STEP_W-1:0];
                CFG_RAMP_STEP:    cfg_reg.ramp_step     <= cfg_data[STEP_W-1:0];
                CFG_AIM_LIMIT:    cfg_reg.aim_limit     <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dcs_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .cmd_byte  (cmd_byte),
        .enc_left  (enc_left),
        .enc_right (enc_right),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    dcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    dcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_not_empty  (q_not_empty),
        .q_op         (head_op),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_pulse   (left_pulse),
        .right_pulse  (right_pulse),
        .base_pulse   (base_pulse),
        .vert_pulse   (vert_pulse),
        .parity_error (parity_error),
        .laser_fire   (laser_fire),
        .count_left   (count_left),
        .count_right  (count_right)
    );

endmodule
`default_nettype wire
